>>> src/assert_macros.svh
// Assertion macros shared by the resequencer RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RSQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
`define RSQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");
`else
`define RSQ_ASSERT(label, clk, rst, prop)
`define RSQ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> src/rsq_pkg.sv
// Shared constants, status codes and the result record of the resequencer.
// Used by rsq_front, rsq_queue and in_order_resequencer; depends on nothing.
package rsq_pkg;

   localparam int WINDOW         = 32;
   localparam int PAYLOAD_BITS   = 32;
   localparam int INDEX_BITS     = 31;
   localparam int DATA_BITS      = 32;
   localparam int STATUS_BITS    = 2;
   localparam int SLOT_BITS      = $clog2(WINDOW);
   localparam int STORE_BITS     = (PAYLOAD_BITS < DATA_BITS) ? PAYLOAD_BITS : DATA_BITS;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int REQ_TDATA_BITS = 64;
   localparam int RSP_TDATA_BITS = 64;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - INDEX_BITS - DATA_BITS;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_IN_ORDER      = 2'd0,
      STATUS_OUT_OF_WINDOW = 2'd1,
      STATUS_STALE         = 2'd2
   } status_type;

   typedef struct packed {
      status_type              status;
      logic [INDEX_BITS-1:0]   index;
      logic [DATA_BITS-1:0]    payload;
      logic                    last;
   } result_type;

endpackage

>>> src/rsq_front.sv
// Front end: classifies each arriving beat, owns the window store and drains held items.
// Depends on rsq_pkg and assert_macros.svh; feeds results to rsq_queue.
`include "assert_macros.svh"

module rsq_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rsq_pkg::INDEX_BITS-1:0]    req_seq_index,
   input  logic [rsq_pkg::DATA_BITS-1:0]     req_payload,
   output logic                              push_valid,
   output rsq_pkg::result_type               push_data,
   input  logic                              push_ready
);
   import rsq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_PUSH
   } state_type;

   function automatic logic [DATA_BITS-1:0] widen(input logic [STORE_BITS-1:0] v);
      logic [DATA_BITS-1:0] r;
      r = '0;
      r[STORE_BITS-1:0] = v;
      return r;
   endfunction

   function automatic logic [SLOT_BITS-1:0] slot_inc(input logic [SLOT_BITS-1:0] s);
      logic [SLOT_BITS-1:0] r;
      if (s == SLOT_BITS'(WINDOW - 1)) begin
         r = '0;
      end else begin
         r = s + SLOT_BITS'(1);
      end
      return r;
   endfunction

   state_type               state_ff, state_in;
   logic [INDEX_BITS-1:0]   expected_ff, expected_in;
   logic [SLOT_BITS-1:0]    head_ff, head_in;
   logic [WINDOW-1:0]       valid_ff, valid_in;
   logic [STORE_BITS-1:0]   slot_mem_ff [WINDOW];
   logic [STORE_BITS-1:0]   rd_data_ff;

   logic [INDEX_BITS-1:0]   gap;
   logic                    in_order;
   logic                    near;
   logic                    early;
   logic                    dup;
   logic                    accept;
   logic                    store_item;
   logic [SLOT_BITS:0]      slot_sum;
   logic [SLOT_BITS-1:0]    slot;
   logic [SLOT_BITS-1:0]    head_next;
   logic [STORE_BITS-1:0]   pay_store;

   // Distance from the expected index, modulo the index range.
   assign gap       = req_seq_index - expected_ff;
   assign in_order  = (gap == '0);
   assign near      = (gap < INDEX_BITS'(WINDOW));
   assign early     = near && !in_order;
   assign slot_sum  = (SLOT_BITS + 1)'(head_ff) + gap[SLOT_BITS:0];
   assign slot      = (slot_sum >= (SLOT_BITS + 1)'(WINDOW)) ?
                      SLOT_BITS'(slot_sum - (SLOT_BITS + 1)'(WINDOW)) : SLOT_BITS'(slot_sum);
   assign dup       = early && valid_ff[slot];
   assign head_next = slot_inc(head_ff);
   assign pay_store = req_payload[STORE_BITS-1:0];

   assign req_tready = (state_ff == ST_IDLE) && push_ready;
   assign accept     = req_tvalid && req_tready;
   assign store_item = accept && early && !dup;

   always_comb begin
      push_valid        = 1'b0;
      push_data.status  = STATUS_IN_ORDER;
      push_data.index   = req_seq_index;
      push_data.payload = widen(pay_store);
      push_data.last    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            push_valid = accept && (in_order || dup || !near);
            if (in_order) begin
               push_data.last = !valid_ff[head_next];
            end else if (dup || gap[INDEX_BITS-1]) begin
               push_data.status = STATUS_STALE;
            end else begin
               push_data.status = STATUS_OUT_OF_WINDOW;
            end
         end
         ST_PUSH: begin
            push_valid        = 1'b1;
            push_data.index   = expected_ff;
            push_data.payload = widen(rd_data_ff);
            push_data.last    = !valid_ff[head_next];
         end
         default: begin
            push_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      expected_in = expected_ff;
      head_in     = head_ff;
      valid_in    = valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && in_order) begin
               expected_in = expected_ff + INDEX_BITS'(1);
               head_in     = head_next;
               if (valid_ff[head_next]) begin
                  state_in = ST_READ;
               end
            end else if (store_item) begin
               valid_in[slot] = 1'b1;
            end
         end
         ST_READ: begin
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (push_ready) begin
               valid_in[head_ff] = 1'b0;
               expected_in       = expected_ff + INDEX_BITS'(1);
               head_in           = head_next;
               state_in          = valid_ff[head_next] ? ST_READ : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         expected_ff <= '0;
         head_ff     <= '0;
         valid_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         expected_ff <= expected_in;
         head_ff     <= head_in;
         valid_ff    <= valid_in;
      end
   end

   // Window store: written on an early arrival that is not a duplicate, read at the head slot while draining.
   always_ff @(posedge clock) begin
      if (store_item) begin
         slot_mem_ff[slot] <= pay_store;
      end
      rd_data_ff <= slot_mem_ff[head_ff];
   end

   `RSQ_ASSERT(a_read_slot_held, clock, reset, (state_ff == ST_READ) |-> valid_ff[head_ff])
   `RSQ_ASSERT(a_in_order_advances, clock, reset, (accept && in_order) |=> (expected_ff == $past(expected_ff) + INDEX_BITS'(1)))
   `RSQ_ASSERT(a_last_ends_drain, clock, reset, (state_ff == ST_PUSH && push_ready && push_data.last) |=> (state_ff == ST_IDLE))

endmodule

>>> src/rsq_queue.sv
// Back end: a short result queue whose head entry drives the response channel.
// Depends on rsq_pkg and assert_macros.svh; filled by rsq_front.
`include "assert_macros.svh"

module rsq_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  rsq_pkg::result_type   push_data,
   output logic                  push_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output rsq_pkg::result_type   rsp_result
);
   import rsq_pkg::*;

   result_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign push_ready = (count_ff != (QPTR_BITS + 1)'(QUEUE_DEPTH));
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_result = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_BITS + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_BITS + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `RSQ_ASSERT(a_count_bound, clock, reset, count_ff <= (QPTR_BITS + 1)'(QUEUE_DEPTH))
   `RSQ_ASSERT(a_pop_drops_count, clock, reset, (pop && !push) |=> (count_ff == $past(count_ff) - (QPTR_BITS + 1)'(1)))
   `RSQ_ASSERT(a_push_raises_count, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + (QPTR_BITS + 1)'(1)))

endmodule

>>> src/in_order_resequencer.sv
// Top level of the in-order resequencer: beat packing and the front/back split.
// Depends on rsq_pkg, rsq_front and rsq_queue.
//
//   Channel   Direction   Handshake               Carries
//   req       in          req_tvalid/req_tready   seq_index, payload
//   rsp       out         rsp_tvalid/rsp_tready   out_index, out_payload, status, last
//
// An in-order, rejected or early beat is taken while the front is idle and the queue
// has room. Each held item that an in-order beat releases goes through ST_READ, the
// registered read of the window store's head slot, then ST_PUSH, its push to the queue.
// While a drain runs the request side is held off; the four-entry result queue lets the
// front keep taking beats while earlier results wait on a stalled response side.
// Reset is synchronous; the slot valid flags sit in flip-flops and clear at once, so there
// is no clearing pass and the first beat may follow reset directly.

module in_order_resequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // seq_index [30:0], payload [62:31], zero pad [63]
   input  logic [rsq_pkg::REQ_TDATA_BITS-1:0]    req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // out_index [30:0], out_payload [62:31], zero pad [63]
   output logic [rsq_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata,
   // status [1:0]
   output logic [rsq_pkg::STATUS_BITS-1:0]       rsp_tuser,
   output logic                                  rsp_tlast
);
   import rsq_pkg::*;

   logic [INDEX_BITS-1:0]  req_seq_index;
   logic [DATA_BITS-1:0]   req_payload;
   logic                   push_valid;
   logic                   push_ready;
   result_type             push_data;
   result_type             rsp_result;

   // Unpack the request beat; bits above the two fields are ignored.
   assign req_seq_index = req_tdata[INDEX_BITS-1:0];
   assign req_payload   = req_tdata[INDEX_BITS+DATA_BITS-1:INDEX_BITS];

   // The front classifies each beat against the expected index, stores early arrivals
   // and walks the run of consecutive held items after an in-order beat.
   rsq_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_seq_index (req_seq_index),
      .req_payload   (req_payload),
      .push_valid    (push_valid),
      .push_data     (push_data),
      .push_ready    (push_ready)
   );

   // The queue decouples result production from the response side's stalls.
   rsq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   // Pack the response beat; the status travels as tuser and the run end as tlast.
   assign rsp_tdata = {{RSP_PAD_BITS{1'b0}}, rsp_result.payload, rsp_result.index};
   assign rsp_tuser = rsp_result.status;
   assign rsp_tlast = rsp_result.last;

endmodule

>>> verif/in_order_resequencer_tb.sv
// Self-checking testbench for in_order_resequencer: sequence-numbered beats in, ordered beats out.
// Depends on rsq_pkg and the in_order_resequencer RTL; needs no files or arguments.
module in_order_resequencer_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import rsq_pkg::*;

   localparam int          ITEM_GOAL   = 400;
   localparam int          TAIL_CYCLES = 120;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          IDLE_PCT    = 13;
   localparam int          HOLD_CYCLES = 250;
   localparam int          HOLD_AT     = 300;
   localparam logic [30:0] HALF_RANGE  = 31'h4000_0000;
   localparam logic [31:0] PAY_KEEP    = (PAYLOAD_BITS >= 32) ? '1 :
                                         ((32'd1 << PAYLOAD_BITS) - 32'd1);

   // One item waiting to be offered. When settle is set, the driver holds it back
   // until every result predicted so far has been seen on the response side.
   typedef struct {
      logic [INDEX_BITS-1:0] index;
      logic [DATA_BITS-1:0]  payload;
      bit                    settle;
   } arrival_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // seq_index [30:0], payload [62:31], zero pad [63]
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // out_index [30:0], out_payload [62:31], zero pad [63]
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   // status [1:0]
   logic [STATUS_BITS-1:0]    rsp_tuser;
   logic                      rsp_tlast;

   arrival_type arrivals[$];    // items not yet offered to the block
   result_type  due_q[$];       // results the block still owes, oldest first
   result_type  released_q[$];  // beats taken from the response side, not yet checked

   // Our own copy of the resequencer state.
   logic [INDEX_BITS-1:0] next_index;
   int                    head_slot;
   bit                    held_valid[WINDOW];
   logic [DATA_BITS-1:0]  held_payload[WINDOW];

   int  beats_in   = 0;
   int  mismatches = 0;
   int  cycles     = 0;
   int  hold_left  = 0;
   bit  hold_done  = 1'b0;
   wire calm       = (beats_in >= 150) && (beats_in < 260);

   in_order_resequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // Moves the head of the window one index forward.
   function automatic void step_head();
      next_index = next_index + 1'b1;
      head_slot  = (head_slot + 1) % WINDOW;
   endfunction

   // Works out the results of one accepted beat and queues them as expectations.
   // The distance is taken modulo 2^31: zero releases a run, a small distance parks
   // the item (or flags it as a duplicate), the upper half of the range is stale and
   // the rest lies beyond the window.
   function automatic void resequence(logic [INDEX_BITS-1:0] idx, logic [DATA_BITS-1:0] pay);
      logic [INDEX_BITS-1:0] gap;
      int                    slot;
      int                    n;
      result_type            r;
      pay       = pay & PAY_KEEP;
      gap       = idx - next_index;
      r.index   = idx;
      r.payload = pay;
      r.last    = 1'b1;
      if (gap == '0) begin
         r.status = STATUS_IN_ORDER;
         r.last   = 1'b0;
         due_q.insert(due_q.size(), r);
         step_head();
         n = 1;
         // Drain the consecutive held items behind the one that just arrived.
         while (n < WINDOW && held_valid[head_slot]) begin
            r.index   = next_index;
            r.payload = held_payload[head_slot];
            due_q.insert(due_q.size(), r);
            held_valid[head_slot] = 1'b0;
            step_head();
            n++;
         end
         r      = due_q.pop_back();
         r.last = 1'b1;
         due_q.insert(due_q.size(), r);
      end else if (gap < WINDOW) begin
         slot = (head_slot + int'(gap)) % WINDOW;
         if (held_valid[slot]) begin
            r.status = STATUS_STALE;
            due_q.insert(due_q.size(), r);
         end else begin
            held_valid[slot]   = 1'b1;
            held_payload[slot] = pay;
         end
      end else if (gap >= HALF_RANGE) begin
         r.status = STATUS_STALE;
         due_q.insert(due_q.size(), r);
      end else begin
         r.status = STATUS_OUT_OF_WINDOW;
         due_q.insert(due_q.size(), r);
      end
   endfunction

   function automatic void offer(logic [INDEX_BITS-1:0] idx, logic [DATA_BITS-1:0] pay,
                                 bit settle);
      arrival_type a;
      a.index   = idx;
      a.payload = pay;
      a.settle  = settle;
      arrivals.insert(arrivals.size(), a);
   endfunction

   function automatic void report(bit known, result_type want, result_type got);
      if (mismatches < 10) begin
         if (known)
            $display("MISMATCH: expected status=%0d index=%h payload=%h last=%b, got status=%0d index=%h payload=%h last=%b",
                     want.status, want.index, want.payload, want.last,
                     got.status, got.index, got.payload, got.last);
         else
            $display("MISMATCH: result with nothing expected: status=%0d index=%h payload=%h last=%b",
                     got.status, got.index, got.payload, got.last);
      end
      mismatches++;
   endfunction

   // Request driver. A beat is predicted on the edge that accepts it; a new one is
   // put up only when the bus is free, and the valid gets one assignment per edge.
   always @(posedge clock) begin
      arrival_type a;
      logic        take;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         next_index = '0;
         head_slot  = 0;
         for (int i = 0; i < WINDOW; i++)
            held_valid[i] = 1'b0;
      end else begin
         take = req_tvalid && req_tready;
         if (take) begin
            resequence(req_tdata[INDEX_BITS-1:0], req_tdata[INDEX_BITS +: DATA_BITS]);
            beats_in <= beats_in + 1;
         end
         if (!req_tvalid || take) begin
            if (arrivals.size() > 0 && !(arrivals[0].settle && due_q.size() > 0) &&
                (calm || $urandom_range(99) >= IDLE_PCT)) begin
               a = arrivals.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, a.payload, a.index};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // One long hold-off on the response side, counted here, so that the result queue
   // fills and the block pushes back on the request side while items keep coming.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && beats_in >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response monitor: collects every accepted beat and sets the next ready.
   always @(posedge clock) begin
      result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status  = status_type'(rsp_tuser);
            got.index   = rsp_tdata[INDEX_BITS-1:0];
            got.payload = rsp_tdata[INDEX_BITS +: DATA_BITS];
            got.last    = rsp_tlast;
            released_q.insert(released_q.size(), got);
         end
         rsp_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
      end
   end

   // Pairing runs on the falling edge, after both rising-edge processes are done,
   // so it never depends on which of them ran first.
   always @(negedge clock) begin
      result_type got;
      result_type want;
      while (released_q.size() > 0) begin
         got = released_q.pop_front();
         if (due_q.size() == 0) begin
            report(1'b0, got, got);
         end else begin
            want = due_q.pop_front();
            if (got.status !== want.status || got.index !== want.index ||
                got.payload !== want.payload || got.last !== want.last)
               report(1'b1, want, got);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      logic [INDEX_BITS-1:0] gen_base;
      logic [INDEX_BITS-1:0] order[WINDOW];
      logic [INDEX_BITS-1:0] tmp;
      logic [INDEX_BITS-1:0] r;
      int                    k;
      int                    j;
      int                    pick;
      int                    goal;
      bit                    settle;
      bit                    mid_done;

      // Directed part. After reset the next index is 0; the comments give the
      // distance seen by the block at the time each beat arrives.
      offer(31'd0,           32'h0000_0000, 1'b0);  // in order, lone result
      offer(31'h7FFF_FFFF,   32'hFFFF_FFFF, 1'b0);  // highest index, just behind: stale
      offer(31'd0,           32'hA5A5_A5A5, 1'b0);  // just behind: stale
      offer(31'd33,          32'h8000_0000, 1'b0);  // first index past the window
      offer(31'h4000_0000,   32'h0000_0001, 1'b0);  // last distance still ahead
      offer(31'h4000_0001,   32'h7FFF_FFFF, 1'b0);  // first distance counted as behind
      offer(31'd32,          32'h1234_5678, 1'b0);  // last slot of the window, parked
      offer(31'd32,          32'hDEAD_BEEF, 1'b0);  // same index again: duplicate
      offer(31'd3,           32'h0F0F_0F0F, 1'b0);  // parked
      offer(31'd2,           32'hF0F0_F0F0, 1'b0);  // parked
      offer(31'd1,           32'h5555_AAAA, 1'b0);  // in order, drains 2 and 3

      // Random part: runs of consecutive indices offered in a shuffled order, so
      // that most items are parked and later drained. A few runs cover the whole
      // window in reverse, which gives the longest drain. Rejected noise is mixed
      // in between. The index wrap at 2^31 lies far beyond the reach of one run.
      goal     = arrivals.size() + ITEM_GOAL;
      gen_base = 31'd4;
      settle   = 1'b1;
      mid_done = 1'b0;
      while (arrivals.size() < goal) begin
         pick = $urandom_range(99);
         if (pick < 6)
            k = WINDOW;
         else if (pick < 20)
            k = $urandom_range(20, 9);
         else
            k = $urandom_range(8, 1);
         for (int i = 0; i < k; i++)
            order[i] = gen_base + 31'(i);
         if (k == WINDOW && $urandom_range(1) == 1) begin
            for (int i = 0; i < k; i++)
               order[i] = gen_base + 31'(k - 1 - i);
         end else begin
            for (int i = k - 1; i > 0; i--) begin
               j        = $urandom_range(i);
               tmp      = order[i];
               order[i] = order[j];
               order[j] = tmp;
            end
         end
         if (!mid_done && arrivals.size() >= goal - ITEM_GOAL / 3) begin
            settle   = 1'b1;
            mid_done = 1'b1;
         end
         for (int i = 0; i < k; i++) begin
            offer(order[i], $urandom, settle);
            settle = 1'b0;
            if ($urandom_range(99) < 12) begin
               case ($urandom_range(3))
                  0: offer(order[$urandom_range(i)], $urandom, 1'b0);
                  1: offer(gen_base - 31'($urandom_range(1000, 1)), $urandom, 1'b0);
                  2: offer(gen_base + 31'(2 * WINDOW) +
                           31'($urandom_range(int'(HALF_RANGE) - 1 - 2 * WINDOW)),
                           $urandom, 1'b0);
                  default: begin
                     // Any index at all, kept clear of the window so that it is
                     // rejected whatever the block's position inside this run.
                     r = 31'($urandom);
                     while (r - gen_base < 31'(2 * WINDOW))
                        r = 31'($urandom);
                     offer(r, $urandom, 1'b0);
                  end
               endcase
            end
         end
         gen_base = gen_base + 31'(k);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (arrivals.size() > 0 || req_tvalid)
         @(posedge clock);
      while (due_q.size() > 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      mismatches += due_q.size();

      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
